/* rtl/dpt_pkg.sv */
// ============================================================================
// dpt_pkg: shared definitions for the demand paging translator
// Sizes, derived widths, the queue item type, the control structs between
// the front and back parts, and the state type of the back sequencer.
// ============================================================================
package dpt_pkg;

    localparam int PAGE_COUNT    = 256;
    localparam int PAGE_BYTES    = 4096;
    localparam int PROCESS_COUNT = 16;
    localparam int FRAME_COUNT   = 1024;

    localparam int PROC_IN_W = 4;
    localparam int VA_W      = 20;
    localparam int PA_W      = 22;

    localparam int OFFSET_W    = $clog2(PAGE_BYTES);
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int PROC_W      = $clog2(PROCESS_COUNT);
    localparam int FRAME_W     = $clog2(FRAME_COUNT);
    localparam int FRAME_CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int SLOT_COUNT  = PROCESS_COUNT * PAGE_COUNT;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int TBL_W       = FRAME_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [PROC_W-1:0]   proc;
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } front_to_back_t;

    typedef struct packed {
        logic pop;
        logic enable;
    } back_to_front_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP
    } back_state_t;

endpackage

/* rtl/dpt_ram.sv */
// ============================================================================
// dpt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module dpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/dpt_front.sv */
// ============================================================================
// dpt_front: request intake and queue
// Accepts items, splits the address into page and offset, and holds them in
// a short queue for the back part.
// ============================================================================
module dpt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dpt_pkg::PROC_IN_W-1:0]   process_number,
    input  logic [dpt_pkg::VA_W-1:0]        virtual_address,
    input  dpt_pkg::back_to_front_t         bk_ctl,
    output dpt_pkg::front_to_back_t         fr_req
);
    import dpt_pkg::*;

    q_item_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    q_item_t           new_item;
    logic              push;
    logic              pop;

    assign in_ready = bk_ctl.enable && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign pop      = bk_ctl.pop;

    always_comb
    begin
        new_item.proc   = PROC_W'(process_number);
        new_item.page   = PAGE_W'(virtual_address >> OFFSET_W);
        new_item.offset = virtual_address[OFFSET_W-1:0];
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign fr_req.valid = (count_reg != '0);
    assign fr_req.item  = queue_reg[rd_ptr_reg];

endmodule

/* rtl/dpt_back.sv */
// ============================================================================
// dpt_back: translation sequencer
// Clears the page table after reset, then looks up each item in the
// translation buffer and page table, allocates frames on faults, updates both
// stores and presents the result in an output register.
// ============================================================================
module dpt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dpt_pkg::front_to_back_t     fr_req,
    output dpt_pkg::back_to_front_t     bk_ctl,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dpt_pkg::PA_W-1:0]    physical_address,
    output logic                        buffer_hit,
    output logic                        page_fault,
    output logic                        frames_exhausted
);
    import dpt_pkg::*;

    back_state_t            state_reg, state_next;
    logic [SLOT_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [PAGE_COUNT-1:0]  buf_valid_reg, buf_valid_next;
    logic [FRAME_CNT_W-1:0] next_frame_reg, next_frame_next;
    q_item_t                work_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [PA_W-1:0]        out_pa_reg;
    logic                   out_hit_reg;
    logic                   out_fault_reg;
    logic                   out_exh_reg;

    logic                   tbl_we;
    logic [SLOT_W-1:0]      tbl_waddr;
    logic [TBL_W-1:0]       tbl_wdata;
    logic [SLOT_W-1:0]      tbl_raddr;
    logic [TBL_W-1:0]       tbl_rdata;
    logic                   buf_we;
    logic [PAGE_W-1:0]      buf_raddr;
    logic [FRAME_W-1:0]     buf_rdata;

    logic                   pop;
    logic                   load_out;
    logic                   dec_hit;
    logic                   dec_fill;
    logic                   dec_fault;
    logic                   dec_exh;
    logic [FRAME_W-1:0]     dec_frame;
    logic [PA_W-1:0]        dec_pa;

    assign tbl_raddr = {fr_req.item.proc, fr_req.item.page};
    assign buf_raddr = fr_req.item.page;

    dpt_ram #(
        .WIDTH (TBL_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    dpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_buffer (
        .clk   (clk),
        .we    (buf_we),
        .waddr (work_reg.page),
        .wdata (dec_frame),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // A page missing from the buffer is filled from the table, or from a new
    // frame when the table has none; with no frame left nothing changes.
    always_comb
    begin
        dec_hit   = buf_valid_reg[work_reg.page];
        dec_fill  = 1'b0;
        dec_fault = 1'b0;
        dec_exh   = 1'b0;
        dec_frame = '0;
        if (dec_hit)
        begin
            dec_frame = buf_rdata;
        end
        else if (tbl_rdata[FRAME_W])
        begin
            dec_frame = tbl_rdata[FRAME_W-1:0];
            dec_fill  = 1'b1;
        end
        else if (next_frame_reg < FRAME_CNT_W'(FRAME_COUNT))
        begin
            dec_frame = next_frame_reg[FRAME_W-1:0];
            dec_fill  = 1'b1;
            dec_fault = 1'b1;
        end
        else
        begin
            dec_exh = 1'b1;
        end
        dec_pa = (dec_hit || dec_fill) ? PA_W'({dec_frame, work_reg.offset}) : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_addr_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (fr_req.valid && (!out_valid_reg || out_ready))
                begin
                    state_next = BK_LOOKUP;
                end
            end
            BK_LOOKUP:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        load_out  = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = {work_reg.proc, work_reg.page};
        tbl_wdata = {1'b1, dec_frame};
        buf_we    = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_addr_reg;
                tbl_wdata = '0;
            end
            BK_IDLE:
            begin
                pop = fr_req.valid && (!out_valid_reg || out_ready);
            end
            BK_LOOKUP:
            begin
                load_out = 1'b1;
                tbl_we   = dec_fault;
                buf_we   = dec_fill;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign bk_ctl.pop    = pop;
    assign bk_ctl.enable = (state_reg != BK_CLEAR);

    always_comb
    begin
        clr_addr_next   = (state_reg == BK_CLEAR) ? clr_addr_reg + SLOT_W'(1) : clr_addr_reg;
        buf_valid_next  = buf_valid_reg;
        next_frame_next = next_frame_reg;
        if (buf_we)
        begin
            buf_valid_next[work_reg.page] = 1'b1;
        end
        if (load_out && dec_fault)
        begin
            next_frame_next = next_frame_reg + FRAME_CNT_W'(1);
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clr_addr_reg   <= '0;
            buf_valid_reg  <= '0;
            next_frame_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            buf_valid_reg  <= buf_valid_next;
            next_frame_reg <= next_frame_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= fr_req.item;
        end
        if (load_out)
        begin
            out_pa_reg    <= dec_pa;
            out_hit_reg   <= dec_hit;
            out_fault_reg <= dec_fault;
            out_exh_reg   <= dec_exh;
        end
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = out_pa_reg;
    assign buffer_hit       = out_hit_reg;
    assign page_fault       = out_fault_reg;
    assign frames_exhausted = out_exh_reg;

endmodule

/* rtl/demand_paging_translator.sv */
// ============================================================================
// demand_paging_translator: virtual to physical address translation
// Translation buffer lookup, per-process page table walk on a miss, and frame
// allocation from an up-counter on a page fault.
// ============================================================================
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------
//  in       | in_valid / in_ready   | process_number, virtual_address
//  out      | out_valid / out_ready | physical_address, buffer_hit,
//           |                       | page_fault, frames_exhausted
//
// In the back sequencer, BK_IDLE pops each item and reads the buffer and
// table RAMs, and BK_LOOKUP resolves it and writes them back. No new item
// is popped while one is being resolved, as the RAM reads are registered.
// After reset the page table is cleared, all 4096 entries, with in_ready low.
// A two-entry queue lets the input side keep accepting while a result waits
// in the output register; the back part stalls only when that register is
// full and not being taken.
module demand_paging_translator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dpt_pkg::PROC_IN_W-1:0] process_number,
    input  logic [dpt_pkg::VA_W-1:0]      virtual_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dpt_pkg::PA_W-1:0]      physical_address,
    output logic                          buffer_hit,
    output logic                          page_fault,
    output logic                          frames_exhausted
);
    import dpt_pkg::*;

    front_to_back_t fr_req;
    back_to_front_t bk_ctl;

    dpt_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .process_number  (process_number),
        .virtual_address (virtual_address),
        .bk_ctl          (bk_ctl),
        .fr_req          (fr_req)
    );

    dpt_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .fr_req           (fr_req),
        .bk_ctl           (bk_ctl),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .physical_address (physical_address),
        .buffer_hit       (buffer_hit),
        .page_fault       (page_fault),
        .frames_exhausted (frames_exhausted)
    );

endmodule

/* rtl/dpt_checker.sv */
// ============================================================================
// dpt_checker: port-level checks for the demand paging translator
// Watches the top-level ports and flags results or handshakes that cannot
// occur in a correct translator.
// ============================================================================
module dpt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dpt_pkg::PA_W-1:0]      physical_address,
    input logic                          buffer_hit,
    input logic                          page_fault,
    input logic                          frames_exhausted
);

    // The table is still being cleared right after reset.
    a_no_intake_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("item intake open while the page table is being cleared");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before it was taken");

    a_fault_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(page_fault && frames_exhausted))
        else $error("fault and frame exhaustion flagged together");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(buffer_hit && (page_fault || frames_exhausted)))
        else $error("buffer hit flagged with a fault or exhaustion");

    a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frames_exhausted) |-> (physical_address == '0))
        else $error("nonzero address returned with no frame left");

endmodule

bind demand_paging_translator dpt_checker u_dpt_checker (.*);
